// ===== hdl/fpu45_pkg.sv =====
// shared types, field positions and function codes of the 45-bit floating-point unit
package fpu45_pkg;

  localparam int WORD_W   = 45;
  localparam int MANT_W   = 36;
  localparam int EXP_W    = 7;
  localparam int TAG_BIT  = 44;
  localparam int SIGN_BIT = 43;
  localparam int EXP_HI   = 42;
  localparam int EXP_LO   = 36;
  localparam int MANT_HI  = 35;
  localparam int HALF_W   = 18;
  localparam int PP_W     = MANT_W + HALF_W;
  localparam int MEXP_W   = 9;

  localparam logic [1:0] FUNC_ADD    = 2'd0;
  localparam logic [1:0] FUNC_SUB    = 2'd1;
  localparam logic [1:0] FUNC_SUBMAG = 2'd2;
  localparam logic [1:0] FUNC_MUL    = 2'd3;

  localparam logic [MEXP_W-1:0] EXP_BIAS = 9'd64;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [MANT_W-1:0] mant_t;
  typedef logic [EXP_W-1:0]  exp_t;
  typedef logic [PP_W-1:0]   pp_t;
  typedef logic [MEXP_W-1:0] mexp_t;

  // after operand decode, alignment setup and partial products
  typedef struct packed {
    logic        is_mul;
    logic        skip_round;
    logic        no_norm;
    logic        tag;
    logic        early;
    word_t       pass_word;
    logic        eff_sub;
    logic        x_sign;
    exp_t        x_exp;
    mant_t       x_mant;
    mant_t       y_mant;
    logic [5:0]  shamt;
    pp_t         pp_hi;
    pp_t         pp_lo;
    mexp_t       m_exp;
    logic        m_sign;
  } prep_t;

  // after mantissa add/subtract and product assembly
  typedef struct packed {
    logic        is_mul;
    logic        skip_round;
    logic        no_norm;
    logic        tag;
    logic        early;
    word_t       pass_word;
    logic        eff_sub;
    logic        sign;
    exp_t        x_exp;
    logic [MANT_W:0] sum;
    mant_t       hi;
    mant_t       lo;
    mexp_t       m_exp;
    logic        m_sign;
  } sum_t;

  // after rounding and range checks
  typedef struct packed {
    logic        is_mul;
    logic        do_norm;
    logic        ovf;
    word_t       word;
    word_t       low;
  } fin_t;

endpackage

// ===== hdl/fpu45_op_if.sv =====
// operand channel: function code, flags and two words
interface fpu45_op_if;
  logic              valid;
  logic              ready;
  logic [1:0]        func;
  logic              skip_round;
  logic              no_norm;
  fpu45_pkg::word_t  operand_a;
  fpu45_pkg::word_t  operand_b;

  modport source (output valid, func, skip_round, no_norm, operand_a, operand_b, input ready);
  modport sink   (input valid, func, skip_round, no_norm, operand_a, operand_b, output ready);
endinterface

// ===== hdl/fpu45_res_if.sv =====
// result channel: result word, omega, low product and overflow
interface fpu45_res_if;
  logic              valid;
  logic              ready;
  fpu45_pkg::word_t  result;
  logic              omega;
  fpu45_pkg::word_t  low_product;
  logic              overflow;

  modport source (output valid, result, omega, low_product, overflow, input ready);
  modport sink   (input valid, result, omega, low_product, overflow, output ready);
endinterface

// ===== hdl/fpu45_prep.sv =====
// stage 1: operand decode, zero and far checks, swap, partial products
module fpu45_prep (
  input  logic              clk,
  input  logic              rst,
  fpu45_op_if.sink          op,
  output logic              dn_valid,
  input  logic              dn_ready,
  output fpu45_pkg::prep_t  dn_data
);

  fpu45_pkg::prep_t data_next;
  fpu45_pkg::prep_t data;
  logic             valid;

  always_comb begin
    fpu45_pkg::word_t a;
    fpu45_pkg::word_t b;
    fpu45_pkg::word_t x;
    fpu45_pkg::word_t y;
    fpu45_pkg::word_t pass;
    fpu45_pkg::exp_t  ae;
    fpu45_pkg::exp_t  be;
    fpu45_pkg::exp_t  diff;
    logic             a_zero;
    logic             b_zero;
    logic             swap;
    logic             far;
    a = op.operand_a;
    b = op.operand_b;
    case (op.func)
      fpu45_pkg::FUNC_SUB: begin
        b[fpu45_pkg::SIGN_BIT] = ~b[fpu45_pkg::SIGN_BIT];
      end
      fpu45_pkg::FUNC_SUBMAG: begin
        a[fpu45_pkg::SIGN_BIT] = 1'b0;
        b[fpu45_pkg::SIGN_BIT] = 1'b1;
      end
      default: begin
      end
    endcase
    ae     = a[fpu45_pkg::EXP_HI:fpu45_pkg::EXP_LO];
    be     = b[fpu45_pkg::EXP_HI:fpu45_pkg::EXP_LO];
    a_zero = (a[fpu45_pkg::EXP_HI:0] == '0);
    b_zero = (b[fpu45_pkg::EXP_HI:0] == '0);
    swap   = (be > ae);
    x      = swap ? b : a;
    y      = swap ? a : b;
    diff   = x[fpu45_pkg::EXP_HI:fpu45_pkg::EXP_LO] - y[fpu45_pkg::EXP_HI:fpu45_pkg::EXP_LO];
    far    = (diff >= fpu45_pkg::EXP_W'(fpu45_pkg::MANT_W));
    pass   = a_zero ? b : (b_zero ? a : x);

    data_next.is_mul     = (op.func == fpu45_pkg::FUNC_MUL);
    data_next.skip_round = op.skip_round;
    data_next.no_norm    = op.no_norm;
    data_next.tag       = a[fpu45_pkg::TAG_BIT] | b[fpu45_pkg::TAG_BIT];
    data_next.early     = a_zero | b_zero | far;
    data_next.pass_word = pass;
    data_next.pass_word[fpu45_pkg::TAG_BIT] = data_next.tag;
    data_next.eff_sub   = x[fpu45_pkg::SIGN_BIT] ^ y[fpu45_pkg::SIGN_BIT];
    data_next.x_sign    = x[fpu45_pkg::SIGN_BIT];
    data_next.x_exp     = x[fpu45_pkg::EXP_HI:fpu45_pkg::EXP_LO];
    data_next.x_mant    = x[fpu45_pkg::MANT_HI:0];
    data_next.y_mant    = y[fpu45_pkg::MANT_HI:0];
    data_next.shamt     = diff[5:0];
    // two 36x18 partial products of the mantissas
    data_next.pp_hi = {{fpu45_pkg::HALF_W{1'b0}}, a[fpu45_pkg::MANT_HI:0]}
                    * {{fpu45_pkg::MANT_W{1'b0}},
                       b[fpu45_pkg::MANT_HI:fpu45_pkg::HALF_W]};
    data_next.pp_lo = {{fpu45_pkg::HALF_W{1'b0}}, a[fpu45_pkg::MANT_HI:0]}
                    * {{fpu45_pkg::MANT_W{1'b0}}, b[fpu45_pkg::HALF_W-1:0]};
    data_next.m_exp  = {2'b00, ae} + {2'b00, be} - fpu45_pkg::EXP_BIAS;
    data_next.m_sign = a[fpu45_pkg::SIGN_BIT] ^ b[fpu45_pkg::SIGN_BIT];
  end

  assign op.ready = !valid || dn_ready;
  assign dn_valid = valid;
  assign dn_data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (op.ready) begin
      valid <= op.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (op.ready && op.valid) begin
      data <= data_next;
    end
  end

endmodule

// ===== hdl/fpu45_sum.sv =====
// stage 2: mantissa alignment and add/subtract, product assembly
module fpu45_sum (
  input  logic              clk,
  input  logic              rst,
  input  logic              up_valid,
  output logic              up_ready,
  input  fpu45_pkg::prep_t  up_data,
  output logic              dn_valid,
  input  logic              dn_ready,
  output fpu45_pkg::sum_t   dn_data
);

  fpu45_pkg::sum_t data_next;
  fpu45_pkg::sum_t data;
  logic            valid;

  always_comb begin
    fpu45_pkg::mant_t ym_sh;
    fpu45_pkg::pp_t   psum;
    logic             ge;
    ym_sh = up_data.y_mant >> up_data.shamt;
    ge    = (up_data.x_mant >= ym_sh);
    psum  = up_data.pp_hi
          + {{fpu45_pkg::HALF_W{1'b0}}, up_data.pp_lo[fpu45_pkg::PP_W-1:fpu45_pkg::HALF_W]};

    data_next.is_mul     = up_data.is_mul;
    data_next.skip_round = up_data.skip_round;
    data_next.no_norm    = up_data.no_norm;
    data_next.tag       = up_data.tag;
    data_next.early     = up_data.early;
    data_next.pass_word = up_data.pass_word;
    data_next.eff_sub   = up_data.eff_sub;
    data_next.x_exp     = up_data.x_exp;
    if (up_data.eff_sub) begin
      data_next.sum  = ge ? {1'b0, up_data.x_mant - ym_sh} : {1'b0, ym_sh - up_data.x_mant};
      data_next.sign = up_data.x_sign ^ !ge;
    end else begin
      data_next.sum  = {1'b0, up_data.x_mant} + {1'b0, ym_sh};
      data_next.sign = up_data.x_sign;
    end
    data_next.hi     = psum[fpu45_pkg::PP_W-1:fpu45_pkg::HALF_W];
    data_next.lo     = {psum[fpu45_pkg::HALF_W-1:0], up_data.pp_lo[fpu45_pkg::HALF_W-1:0]};
    data_next.m_exp  = up_data.m_exp;
    data_next.m_sign = up_data.m_sign;
  end

  assign up_ready = !valid || dn_ready;
  assign dn_valid = valid;
  assign dn_data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data <= data_next;
    end
  end

endmodule

// ===== hdl/fpu45_round.sv =====
// stage 3: carry rounding, product normalize/round, range checks
module fpu45_round (
  input  logic              clk,
  input  logic              rst,
  input  logic              up_valid,
  output logic              up_ready,
  input  fpu45_pkg::sum_t   up_data,
  output logic              dn_valid,
  input  logic              dn_ready,
  output fpu45_pkg::fin_t   dn_data
);

  fpu45_pkg::fin_t data_next;
  fpu45_pkg::fin_t data;
  logic            valid;

  always_comb begin
    fpu45_pkg::word_t tag_only;
    fpu45_pkg::mant_t hi;
    fpu45_pkg::mant_t lo;
    fpu45_pkg::mexp_t e;
    logic [fpu45_pkg::MANT_W:0] r;
    logic [fpu45_pkg::EXP_W:0]  ex_inc;
    tag_only = '0;
    tag_only[fpu45_pkg::TAG_BIT] = up_data.tag;
    hi     = up_data.hi;
    lo     = up_data.lo;
    e      = up_data.m_exp;
    r      = up_data.skip_round ? up_data.sum
                                : up_data.sum + {{fpu45_pkg::MANT_W{1'b0}}, 1'b1};
    ex_inc = {1'b0, up_data.x_exp} + {{fpu45_pkg::EXP_W{1'b0}}, 1'b1};

    data_next.is_mul  = up_data.is_mul;
    data_next.do_norm = 1'b0;
    data_next.ovf     = 1'b0;
    data_next.word    = tag_only;
    data_next.low     = '0;

    if (up_data.is_mul) begin
      // one-place left normalize, otherwise round on the top low bit
      if (!up_data.no_norm && !hi[fpu45_pkg::MANT_HI]) begin
        e        = e - 9'd1;
        {hi, lo} = {hi, lo} << 1;
      end else if (!up_data.skip_round && lo[fpu45_pkg::MANT_HI]) begin
        hi = hi + 36'd1;
      end
      if (hi == '0 || e[fpu45_pkg::MEXP_W-1]) begin
        data_next.low = {{(fpu45_pkg::WORD_W-fpu45_pkg::MANT_W){1'b0}}, lo};
      end else if (e[fpu45_pkg::EXP_W]) begin
        data_next.ovf = 1'b1;
      end else begin
        data_next.word = {up_data.tag, up_data.m_sign, e[fpu45_pkg::EXP_W-1:0], hi};
        data_next.low  = {up_data.tag, up_data.m_sign, e[fpu45_pkg::EXP_W-1:0], lo};
      end
    end else if (up_data.early) begin
      data_next.word    = up_data.pass_word;
      data_next.do_norm = !up_data.no_norm;
    end else if (!up_data.eff_sub && up_data.sum[fpu45_pkg::MANT_W]) begin
      // mantissa carry: shift right one place, bump the exponent
      if (ex_inc[fpu45_pkg::EXP_W]) begin
        data_next.ovf = 1'b1;
      end else begin
        data_next.word = {up_data.tag, up_data.sign, ex_inc[fpu45_pkg::EXP_W-1:0],
                          r[fpu45_pkg::MANT_W:1]};
        data_next.do_norm = !up_data.no_norm;
      end
    end else begin
      data_next.word = {up_data.tag, up_data.sign, up_data.x_exp,
                        up_data.sum[fpu45_pkg::MANT_HI:0]};
      data_next.do_norm = !up_data.no_norm;
    end
  end

  assign up_ready = !valid || dn_ready;
  assign dn_valid = valid;
  assign dn_data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data <= data_next;
    end
  end

endmodule

// ===== hdl/fpu45_norm.sv =====
// stage 4: left normalization, omega and output register
module fpu45_norm (
  input  logic              clk,
  input  logic              rst,
  input  logic              up_valid,
  output logic              up_ready,
  input  fpu45_pkg::fin_t   up_data,
  fpu45_res_if.source       res
);

  fpu45_pkg::word_t result_next;
  fpu45_pkg::word_t result;
  logic             omega;
  fpu45_pkg::word_t low_product;
  logic             overflow;
  logic             valid;

  // leading-zero shift in six binary steps
  function automatic fpu45_pkg::word_t norm_left(input fpu45_pkg::word_t w);
    fpu45_pkg::mant_t m;
    fpu45_pkg::exp_t  e;
    fpu45_pkg::word_t r;
    logic [5:0]       lz;
    m  = w[fpu45_pkg::MANT_HI:0];
    e  = w[fpu45_pkg::EXP_HI:fpu45_pkg::EXP_LO];
    lz = '0;
    if (m[35:4] == '0) begin
      m  = m << 32;
      lz = lz + 6'd32;
    end
    if (m[35:20] == '0) begin
      m  = m << 16;
      lz = lz + 6'd16;
    end
    if (m[35:28] == '0) begin
      m  = m << 8;
      lz = lz + 6'd8;
    end
    if (m[35:32] == '0) begin
      m  = m << 4;
      lz = lz + 6'd4;
    end
    if (m[35:34] == '0) begin
      m  = m << 2;
      lz = lz + 6'd2;
    end
    if (!m[35]) begin
      m  = m << 1;
      lz = lz + 6'd1;
    end
    r = '0;
    r[fpu45_pkg::TAG_BIT] = w[fpu45_pkg::TAG_BIT];
    if (m[35] && e >= {1'b0, lz}) begin
      r = {w[fpu45_pkg::TAG_BIT], w[fpu45_pkg::SIGN_BIT], e - {1'b0, lz}, m};
    end
    return r;
  endfunction

  assign result_next = up_data.do_norm ? norm_left(up_data.word) : up_data.word;

  assign up_ready        = !valid || res.ready;
  assign res.valid       = valid;
  assign res.result      = result;
  assign res.omega       = omega;
  assign res.low_product = low_product;
  assign res.overflow    = overflow;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      result      <= result_next;
      omega       <= up_data.is_mul
                     ? (result_next[fpu45_pkg::EXP_HI:fpu45_pkg::EXP_LO] > 7'd64)
                     : result_next[fpu45_pkg::SIGN_BIT];
      low_product <= up_data.low;
      overflow    <= up_data.ovf;
    end
  end

endmodule

// ===== hdl/float45_add_sub_multiply_unit.sv =====
// top level of the 45-bit floating-point add/subtract/multiply unit
// each accepted operand passes the prep, sum, round and norm registers to its result
// throughput: one transaction per cycle; the four register stages are each gated by
//   the stage below, so a stalled result holds the pipe without loss or repeats
// reset (rst, synchronous) clears the four stage valid bits; payload registers keep junk
module float45_add_sub_multiply_unit (
  input  logic        clk,
  input  logic        rst,
  fpu45_op_if.sink    op_chan,
  fpu45_res_if.source res_chan
);

  // stage 1 -> 2
  logic             prep_valid;
  logic             prep_ready;
  fpu45_pkg::prep_t prep_data;
  // stage 2 -> 3
  logic             sum_valid;
  logic             sum_ready;
  fpu45_pkg::sum_t  sum_data;
  // stage 3 -> 4
  logic             fin_valid;
  logic             fin_ready;
  fpu45_pkg::fin_t  fin_data;

  // decode function code, find zero/negligible operands, order by exponent,
  // and form the two 36x18 partial products
  fpu45_prep u_prep (
    .clk      (clk),
    .rst      (rst),
    .op       (op_chan),
    .dn_valid (prep_valid),
    .dn_ready (prep_ready),
    .dn_data  (prep_data)
  );

  // align the smaller operand and add or subtract magnitudes;
  // sum partial products into the 72-bit product
  fpu45_sum u_sum (
    .clk      (clk),
    .rst      (rst),
    .up_valid (prep_valid),
    .up_ready (prep_ready),
    .up_data  (prep_data),
    .dn_valid (sum_valid),
    .dn_ready (sum_ready),
    .dn_data  (sum_data)
  );

  // handle the mantissa carry with rounding, normalize or round the product,
  // and check exponent underflow and overflow
  fpu45_round u_round (
    .clk      (clk),
    .rst      (rst),
    .up_valid (sum_valid),
    .up_ready (sum_ready),
    .up_data  (sum_data),
    .dn_valid (fin_valid),
    .dn_ready (fin_ready),
    .dn_data  (fin_data)
  );

  // left normalize add-group results, derive omega, drive the result channel
  fpu45_norm u_norm (
    .clk      (clk),
    .rst      (rst),
    .up_valid (fin_valid),
    .up_ready (fin_ready),
    .up_data  (fin_data),
    .res      (res_chan)
  );

endmodule
